// File: sv/checkpoint_container_validator_defines.svh
// Assertion macros used by the checkpoint container validator port checker.
`ifndef CHECKPOINT_CONTAINER_VALIDATOR_DEFINES_SVH
`define CHECKPOINT_CONTAINER_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("checker: same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("checker: next-cycle implication failed");

`endif

// File: sv/ccv_pkg.sv
// Types and constants of the checkpoint container validator.
package ccv_pkg;

  // Status codes of one result item
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_MAGIC     = 4'd1,
    ST_VERSION   = 4'd2,
    ST_DAY       = 4'd3,
    ST_COUNT     = 4'd4,
    ST_EMPTY     = 4'd5,
    ST_ORDER     = 4'd6,
    ST_TRUNCATED = 4'd7,
    ST_CHECKSUM  = 4'd8,
    ST_TRAILING  = 4'd9
  } status_t;

  // One input item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [31:0] version;
    logic [63:0] day;
    logic [2:0]  count;
  } result_t;

  // FNV-1a 64 offset basis
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  // Container magic, first byte at index 0
  localparam logic [0:7][7:0] MAGIC = {"W", "S", "S", "I", "M", "0", "0", "1"};

endpackage

// File: sv/ccv_fnv.sv
// One FNV-1a 64 round: xor in a byte, multiply by the prime as shifted adds.
module ccv_fnv (
  input  logic [63:0] hash,
  input  logic [7:0]  data,
  output logic [63:0] hash_next
);

  logic [63:0] x;

  // Prime is 2^40 + 2^8 + 0xb3, and 0xb3 = 2^7 + 2^5 + 2^4 + 2^1 + 1
  assign x = hash ^ {56'b0, data};
  assign hash_next = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                   + (x << 1) + x;

endmodule

// File: sv/ccv_core.sv
// Parse state, section tables and status logic of the container validator.
module ccv_core #(
  parameter int MAX_SECTIONS = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  ccv_pkg::item_t   item,
  output ccv_pkg::result_t result
);

  localparam int IW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  localparam logic [4:0] HDR_MAGIC_END    = 5'd8;
  localparam logic [4:0] HDR_FIELD_SPLIT  = 5'd12;
  localparam logic [4:0] HDR_VERSION_LAST = 5'd11;
  localparam logic [4:0] HDR_DAY_LAST     = 5'd19;
  localparam logic [4:0] HDR_COUNT_LAST   = 5'd23;
  localparam logic [4:0] DESC_ID_END      = 5'd4;
  localparam logic [4:0] DESC_ID_LAST     = 5'd3;
  localparam logic [4:0] DESC_SIZE_LAST   = 5'd11;
  localparam logic [4:0] DESC_SUM_LAST    = 5'd19;

  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_DESC = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  // Control state
  phase_t           phase, phase_next;
  logic [4:0]       header_offset, header_offset_next;
  logic [4:0]       desc_byte, desc_byte_next;
  logic [63:0]      field_shift, field_shift_next;
  logic [31:0]      version_reg, version_next;
  logic [63:0]      day_reg, day_next;
  logic [2:0]       count_reg, count_next;
  logic             order_ok, order_ok_next;
  logic [2:0]       current_section, current_section_next;
  logic [63:0]      bytes_left, bytes_left_next;
  logic [63:0]      running_hash, running_hash_next;
  ccv_pkg::status_t fault_code, error_next;
  logic             sum_bad, sum_bad_next;

  // Section tables, written before read
  logic [63:0] section_sizes [MAX_SECTIONS];
  logic [63:0] section_sums  [MAX_SECTIONS];
  logic        size_zero, size_zero_next;
  logic        size_we, sum_we;
  logic [IW-1:0] wr_idx, size_rd_idx;
  logic [63:0] size_rd, sum_rd;

  // Datapath helpers
  logic [2:0]  cur_plus1;
  logic [4:0]  off_p4, desc_p4;
  logic [2:0]  lane_pos;
  logic [63:0] gathered;
  logic [63:0] hash_step;
  logic [63:0] left_dec;
  logic [2:0]  want;
  logic        want_over;

  ccv_fnv u_fnv (
    .hash      (running_hash),
    .data      (item.data),
    .hash_next (hash_step)
  );

  assign cur_plus1   = current_section + 3'd1;
  assign wr_idx      = IW'(current_section);
  assign size_rd_idx = (phase == PH_PAY) ? IW'(cur_plus1) : '0;
  assign size_rd     = section_sizes[size_rd_idx];
  assign sum_rd      = section_sums[wr_idx];
  assign left_dec    = bytes_left - 64'd1;

  // Place the byte into its lane of the field being gathered
  assign off_p4   = header_offset + 5'd4;
  assign desc_p4  = desc_byte + 5'd4;
  always_comb begin
    if (phase == PH_HEAD) begin
      lane_pos = (header_offset < HDR_FIELD_SPLIT) ? header_offset[2:0] : off_p4[2:0];
    end else begin
      lane_pos = (desc_byte < DESC_ID_END) ? desc_byte[2:0] : desc_p4[2:0];
    end
  end
  assign gathered = field_shift | ({56'b0, item.data} << {lane_pos, 3'b000});

  // Section count expected for the version
  assign want      = (version_reg == 32'd1) ? 3'd3 : ((version_reg == 32'd2) ? 3'd4 : 3'd5);
  assign want_over = {29'b0, want} > 32'(MAX_SECTIONS);

  // Work out the state after this item
  always_comb begin
    phase_next           = phase;
    header_offset_next   = header_offset;
    desc_byte_next       = desc_byte;
    field_shift_next     = field_shift;
    version_next         = version_reg;
    day_next             = day_reg;
    count_next           = count_reg;
    order_ok_next        = order_ok;
    current_section_next = current_section;
    bytes_left_next      = bytes_left;
    running_hash_next    = running_hash;
    error_next           = fault_code;
    sum_bad_next         = sum_bad;
    size_zero_next       = size_zero;
    size_we              = 1'b0;
    sum_we               = 1'b0;
    if (fault_code == ccv_pkg::ST_OK) begin
      case (phase)
        PH_HEAD: begin
          if (header_offset < HDR_MAGIC_END) begin
            if (item.data != ccv_pkg::MAGIC[header_offset[2:0]]) begin
              error_next = ccv_pkg::ST_MAGIC;
            end else begin
              header_offset_next = header_offset + 5'd1;
            end
          end else begin
            field_shift_next   = gathered;
            header_offset_next = header_offset + 5'd1;
            if (header_offset == HDR_VERSION_LAST) begin
              version_next     = gathered[31:0];
              field_shift_next = '0;
              if (gathered[31:0] < 32'd1 || gathered[31:0] > 32'd3) begin
                error_next = ccv_pkg::ST_VERSION;
              end
            end else if (header_offset == HDR_DAY_LAST) begin
              day_next         = gathered;
              field_shift_next = '0;
              if (gathered[63]) begin
                error_next = ccv_pkg::ST_DAY;
              end
            end else if (header_offset == HDR_COUNT_LAST) begin
              field_shift_next = '0;
              if (gathered != {61'b0, want} || want_over) begin
                error_next = ccv_pkg::ST_COUNT;
              end else begin
                count_next           = want;
                phase_next           = PH_DESC;
                current_section_next = '0;
                desc_byte_next       = '0;
              end
            end
          end
        end
        PH_DESC: begin
          field_shift_next = gathered;
          desc_byte_next   = desc_byte + 5'd1;
          if (desc_byte == DESC_ID_LAST) begin
            field_shift_next = '0;
            if (gathered != {61'b0, cur_plus1}) begin
              order_ok_next = 1'b0;
            end
          end else if (desc_byte == DESC_SIZE_LAST) begin
            field_shift_next = '0;
            size_we          = 1'b1;
            size_zero_next   = (gathered == 64'd0);
          end else if (desc_byte == DESC_SUM_LAST) begin
            field_shift_next = '0;
            sum_we           = 1'b1;
            if (size_zero) begin
              error_next = ccv_pkg::ST_EMPTY;
            end else begin
              desc_byte_next       = '0;
              current_section_next = cur_plus1;
              if (cur_plus1 >= count_reg) begin
                if (!order_ok) begin
                  error_next = ccv_pkg::ST_ORDER;
                end else begin
                  phase_next           = PH_PAY;
                  current_section_next = '0;
                  bytes_left_next      = size_rd;
                  running_hash_next    = ccv_pkg::FNV_BASIS;
                end
              end
            end
          end
        end
        PH_PAY: begin
          running_hash_next = hash_step;
          bytes_left_next   = left_dec;
          if (left_dec == 64'd0) begin
            if (hash_step != sum_rd) begin
              sum_bad_next = 1'b1;
            end
            current_section_next = cur_plus1;
            if (cur_plus1 >= count_reg) begin
              phase_next = PH_DONE;
            end else begin
              bytes_left_next   = size_rd;
              running_hash_next = ccv_pkg::FNV_BASIS;
            end
          end
        end
        PH_DONE: begin
          error_next = ccv_pkg::ST_TRAILING;
        end
        default: begin
        end
      endcase
    end
  end

  // Form the result from the state after this item
  always_comb begin
    if (error_next != ccv_pkg::ST_OK) begin
      result.status = error_next;
    end else if (phase_next != PH_DONE) begin
      result.status = (phase_next == PH_HEAD && header_offset_next < HDR_MAGIC_END) ?
                      ccv_pkg::ST_MAGIC : ccv_pkg::ST_TRUNCATED;
    end else begin
      result.status = sum_bad_next ? ccv_pkg::ST_CHECKSUM : ccv_pkg::ST_OK;
    end
    result.version = version_next;
    result.day     = day_next;
    result.count   = count_next;
  end

  // Advance the control state; start over after the last item
  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      phase           <= PH_HEAD;
      header_offset   <= '0;
      desc_byte       <= '0;
      field_shift     <= '0;
      version_reg     <= '0;
      day_reg         <= '0;
      count_reg       <= '0;
      order_ok        <= 1'b1;
      current_section <= '0;
      bytes_left      <= '0;
      running_hash    <= ccv_pkg::FNV_BASIS;
      fault_code      <= ccv_pkg::ST_OK;
      sum_bad         <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      header_offset   <= header_offset_next;
      desc_byte       <= desc_byte_next;
      field_shift     <= field_shift_next;
      version_reg     <= version_next;
      day_reg         <= day_next;
      count_reg       <= count_next;
      order_ok        <= order_ok_next;
      current_section <= current_section_next;
      bytes_left      <= bytes_left_next;
      running_hash    <= running_hash_next;
      fault_code      <= error_next;
      sum_bad         <= sum_bad_next;
    end
  end

  // Write descriptor fields into the section tables
  always_ff @(posedge clk) begin
    if (take) begin
      size_zero <= size_zero_next;
      if (size_we) begin
        section_sizes[wr_idx] <= gathered;
      end
      if (sum_we) begin
        section_sums[wr_idx] <= gathered;
      end
    end
  end

endmodule

// File: sv/checkpoint_container_validator.sv
// Top level of the checkpoint container validator: input stage, core, result register.
//
//   channel   signals                                              role
//   data      data_valid data_ready data_byte last_byte            one file byte per item
//   result    result_valid result_ready status format_version      one status per file,
//             global_day section_count                             on the last byte
//
// One byte per cycle sustained; the FNV round and the 64-bit counter update
// in the core set the clock path. A result is registered from the input stage.
// Only a last byte waits, and only while the result register is still full.
// Reset clears all control state; the section tables need no clearing.
module checkpoint_container_validator #(
  parameter int MAX_SECTIONS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  output logic               data_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [3:0]         status,
  output logic [31:0]        format_version,
  output logic signed [63:0] global_day,
  output logic [2:0]         section_count
);

  logic              stg_valid;
  ccv_pkg::item_t    stg_item;
  logic              take;
  ccv_pkg::result_t  core_result;
  ccv_pkg::result_t  res;

  // Consume the staged item unless it is a last byte facing a stalled result register
  assign take       = stg_valid && (!stg_item.last || !result_valid || result_ready);
  assign data_ready = !stg_valid || take;

  // Hold the accepted item for the core
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (data_ready) begin
      stg_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_ready && data_valid) begin
      stg_item.data <= data_byte;
      stg_item.last <= last_byte;
    end
  end

  ccv_core #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .item   (stg_item),
    .result (core_result)
  );

  // Load the result register on a last byte, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take && stg_item.last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && stg_item.last) begin
      res <= core_result;
    end
  end

  assign status         = res.status;
  assign format_version = res.version;
  assign global_day     = signed'(res.day);
  assign section_count  = res.count;

endmodule

// File: sv/ccv_checker.sv
// Port-level checker of the checkpoint container validator, bound to the top level.
`include "checkpoint_container_validator_defines.svh"

module ccv_checker (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input logic [3:0]         status,
  input logic [31:0]        format_version,
  input logic signed [63:0] global_day,
  input logic [2:0]         section_count
);

  // A stalled result holds
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(status) && $stable(global_day))

  // A clean container has a valid header behind it
  `ASSERT_IMPLY(a_ok_header, clk, rst, result_valid && status == ccv_pkg::ST_OK, section_count != 3'd0 && format_version != 32'd0 && !global_day[63])

  // A bad magic stops before any header field
  `ASSERT_IMPLY(a_magic_empty, clk, rst, result_valid && status == ccv_pkg::ST_MAGIC, format_version == 32'd0 && section_count == 3'd0)

  // An accepted count matches its version
  `ASSERT_IMPLY(a_count_version, clk, rst, result_valid && section_count != 3'd0, (section_count == 3'd3 || section_count == 3'd4 || section_count == 3'd5) && format_version == {29'b0, section_count} - 32'd2)

endmodule

bind checkpoint_container_validator ccv_checker u_ccv_checker (.*);

// File: verif/checkpoint_container_checker.sv
// Checker for the container validator: tracks the byte stream, predicts each status item and compares.
module checkpoint_container_checker #(
  parameter int MAX_SECTIONS = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               data_valid,
  input  logic               data_ready,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic [3:0]         status,
  input  logic [31:0]        format_version,
  input  logic signed [63:0] global_day,
  input  logic [2:0]         section_count,
  output int                 mismatches,
  output int                 reports_due
);

  localparam logic [63:0] HASH_SEED  = 64'hcbf29ce484222325;
  localparam logic [63:0] HASH_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] MAGIC_TEXT = "WSSIM001";

  typedef enum logic [1:0] {
    AT_HEADER,
    AT_TABLE,
    AT_PAYLOAD,
    AT_END
  } stage_t;

  // Parser state of the container in flight
  logic [6:0]  hdr_pos;
  logic [63:0] acc;
  logic [31:0] ver_q;
  logic [63:0] day_q;
  logic [2:0]  cnt_q;
  logic [63:0] sec_len [MAX_SECTIONS];
  logic [63:0] sec_fnv [MAX_SECTIONS];
  logic        ids_ok;
  logic [2:0]  sec_no;
  logic [63:0] left;
  logic [63:0] hash;
  ccv_pkg::status_t err;
  stage_t      stage;
  logic [4:0]  tbl_pos;
  logic        fnv_bad;

  // Status items owed by the block, oldest first
  ccv_pkg::result_t due_reports [$];
  ccv_pkg::result_t oldest;

  initial mismatches = 0;

  function automatic void clear_parser();
    hdr_pos = '0;
    acc     = '0;
    ver_q   = '0;
    day_q   = '0;
    cnt_q   = '0;
    ids_ok  = 1'b1;
    sec_no  = '0;
    left    = '0;
    hash    = HASH_SEED;
    err     = ccv_pkg::ST_OK;
    stage   = AT_HEADER;
    tbl_pos = '0;
    fnv_bad = 1'b0;
  endfunction

  // Shift one byte into the little-endian field being collected
  function automatic void gather(int pos, logic [7:0] b);
    acc = acc | (64'(b) << (8 * (pos % 8)));
  endfunction

  function automatic void open_section();
    left = sec_len[int'(sec_no) % MAX_SECTIONS];
    hash = HASH_SEED;
  endfunction

  function automatic void header_step(logic [7:0] b);
    int unsigned off;
    logic [63:0] want;
    off = hdr_pos;
    if (off < 8) begin
      if (b != MAGIC_TEXT[63 - 8 * off -: 8]) begin
        err = ccv_pkg::ST_MAGIC;
        return;
      end
    end else if (off < 12) begin
      gather(off - 8, b);
      if (off == 11) begin
        ver_q = acc[31:0];
        acc = '0;
        if (ver_q < 1 || ver_q > 3) begin
          err = ccv_pkg::ST_VERSION;
          return;
        end
      end
    end else if (off < 20) begin
      gather(off - 12, b);
      if (off == 19) begin
        day_q = acc;
        acc = '0;
        if (day_q[63]) begin
          err = ccv_pkg::ST_DAY;
          return;
        end
      end
    end else begin
      gather(off - 20, b);
      if (off == 23) begin
        want = (ver_q == 1) ? 64'd3 : ((ver_q == 2) ? 64'd4 : 64'd5);
        if (acc != want || want > MAX_SECTIONS) begin
          acc = '0;
          err = ccv_pkg::ST_COUNT;
          return;
        end
        acc     = '0;
        cnt_q   = want[2:0];
        stage   = AT_TABLE;
        sec_no  = '0;
        tbl_pos = '0;
      end
    end
    hdr_pos = 7'(off + 1);
  endfunction

  // Descriptor table: id, size, checksum per section
  function automatic void table_step(logic [7:0] b);
    int k;
    int idx;
    k = tbl_pos;
    idx = int'(sec_no) % MAX_SECTIONS;
    if (k < 4) begin
      gather(k, b);
      if (k == 3) begin
        if (acc != 64'(sec_no) + 64'd1) ids_ok = 1'b0;
        acc = '0;
      end
    end else if (k < 12) begin
      gather(k - 4, b);
      if (k == 11) begin
        sec_len[idx] = acc;
        acc = '0;
      end
    end else begin
      gather(k - 12, b);
      if (k == 19) begin
        sec_fnv[idx] = acc;
        acc = '0;
        if (sec_len[idx] == 0) begin
          err = ccv_pkg::ST_EMPTY;
          return;
        end
        tbl_pos = '0;
        sec_no = sec_no + 3'd1;
        // Order errors surface only once the whole table is in
        if (sec_no >= cnt_q) begin
          if (!ids_ok) begin
            err = ccv_pkg::ST_ORDER;
            return;
          end
          stage  = AT_PAYLOAD;
          sec_no = '0;
          open_section();
        end
        return;
      end
    end
    tbl_pos = 5'(k + 1);
  endfunction

  function automatic void payload_step(logic [7:0] b);
    hash = (hash ^ 64'(b)) * HASH_PRIME;
    left = left - 64'd1;
    if (left != 0) return;
    if (hash != sec_fnv[int'(sec_no) % MAX_SECTIONS]) fnv_bad = 1'b1;
    sec_no = sec_no + 3'd1;
    if (sec_no >= cnt_q) stage = AT_END;
    else open_section();
  endfunction

  // Advance the parser by one accepted byte; queue a status item on the last one
  function automatic void parse_byte(logic [7:0] b, logic fin);
    ccv_pkg::status_t st;
    ccv_pkg::result_t rep;
    if (err == ccv_pkg::ST_OK) begin
      case (stage)
        AT_HEADER:  header_step(b);
        AT_TABLE:   table_step(b);
        AT_PAYLOAD: payload_step(b);
        default:    err = ccv_pkg::ST_TRAILING;
      endcase
    end
    if (!fin) return;
    if (err != ccv_pkg::ST_OK) st = err;
    else if (stage != AT_END)
      st = (stage == AT_HEADER && hdr_pos < 8) ? ccv_pkg::ST_MAGIC : ccv_pkg::ST_TRUNCATED;
    else st = fnv_bad ? ccv_pkg::ST_CHECKSUM : ccv_pkg::ST_OK;
    rep.status  = st;
    rep.version = ver_q;
    rep.day     = day_q;
    rep.count   = cnt_q;
    due_reports.insert(due_reports.size(), rep);
    clear_parser();
  endfunction

  function automatic void flag_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare each delivered status item, then fold in the accepted byte
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      due_reports.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (due_reports.size() == 0) begin
          $display("%0t: status item %0d with nothing expected", $time, status);
          mismatches++;
        end else begin
          oldest = due_reports.pop_front();
          flag_field("status", 64'(oldest.status), 64'(status));
          flag_field("format_version", 64'(oldest.version), 64'(format_version));
          flag_field("global_day", oldest.day, global_day);
          flag_field("section_count", 64'(oldest.count), 64'(section_count));
        end
      end
      if (data_valid && data_ready) parse_byte(data_byte, last_byte);
    end
    reports_due <= due_reports.size();
  end

endmodule

// File: verif/checkpoint_container_validator_tb.sv
// Testbench top for the container validator: clock, reset, container stimulus and verdict.
module checkpoint_container_validator_tb;

  localparam logic [63:0] HASH_SEED   = 64'hcbf29ce484222325;
  localparam logic [63:0] HASH_PRIME  = 64'h00000100000001b3;
  localparam logic [63:0] MAGIC_TEXT  = "WSSIM001";
  localparam int          LONG_HOLD   = 400;
  localparam int          STALL_LIMIT = 5000;

  // Ways a generated container departs from a clean one
  typedef enum int {
    CLEAN,
    BAD_SUM,
    BAD_MAGIC,
    SHORT_MAGIC,
    BAD_VERSION,
    NEG_DAY,
    BAD_COUNT,
    EMPTY_SECTION,
    BAD_ORDER,
    ORDER_THEN_EMPTY,
    CUT_SHORT,
    HUGE_SECTION,
    EXTRA_BYTES,
    NOISE
  } flaw_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               data_valid = 1'b0;
  logic               data_ready;
  logic [7:0]         data_byte = 8'h00;
  logic               last_byte = 1'b0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [3:0]         status;
  logic [31:0]        format_version;
  logic signed [63:0] global_day;
  logic [2:0]         section_count;

  int                 mismatches;
  int                 reports_due;
  logic               long_hold_go = 1'b0;
  int                 hold_cycles = 0;
  int                 mode = 0;
  int                 mode_left = 0;
  int                 burst_left = 0;
  logic [7:0]         img [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  checkpoint_container_validator i_dut (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_ready    (data_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .format_version(format_version),
    .global_day    (global_day),
    .section_count (section_count)
  );

  checkpoint_container_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_ready    (data_ready),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .status        (status),
    .format_version(format_version),
    .global_day    (global_day),
    .section_count (section_count),
    .mismatches    (mismatches),
    .reports_due   (reports_due)
  );

  // Receiver: one long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (long_hold_go && hold_cycles < LONG_HOLD) begin
      hold_cycles  <= hold_cycles + 1;
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ~result_ready;
        2:       result_ready <= 1'($urandom_range(0, 1));
        default: result_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  function automatic void append_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) img.insert(img.size(), v[8 * i +: 8]);
  endfunction

  // Build one container into img; return how many of its bytes to send
  function automatic int build(flaw_t flaw);
    logic [31:0] ver;
    logic [31:0] cnt_field;
    logic [63:0] day;
    logic [63:0] h;
    logic [63:0] len [5];
    logic [63:0] sum [5];
    logic [31:0] id [5];
    logic [7:0]  body [$];
    logic [7:0]  b;
    int          n;
    int          victim;
    int          gen;
    int          err_at;
    int          keep;
    img.delete();
    if (flaw == NOISE) begin
      repeat ($urandom_range(1, 12)) img.insert(img.size(), 8'($urandom));
      return img.size();
    end
    ver = $urandom_range(1, 3);
    n = ver + 2;
    day = {1'b0, 31'($urandom), 32'($urandom)};
    if ($urandom_range(0, 5) == 0) day = $urandom_range(0, 1) ? 64'd0 : {1'b0, {63{1'b1}}};
    cnt_field = n;
    victim = $urandom_range(0, n - 1);
    for (int s = 0; s < 5; s++) begin
      len[s] = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(4, 16)) : 64'($urandom_range(1, 3));
      id[s] = s + 1;
    end

    // Apply the flaw to the header and table fields
    case (flaw)
      BAD_VERSION: begin
        if ($urandom_range(0, 2) == 0) ver = 32'd0;
        else ver = $urandom_range(0, 1) ? 32'hffff_ffff : (32'($urandom) | 32'h4);
      end
      NEG_DAY: day[63] = 1'b1;
      BAD_COUNT: begin
        cnt_field = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : 32'($urandom);
        if (cnt_field == n) cnt_field = cnt_field + 1;
      end
      EMPTY_SECTION: len[victim] = 64'd0;
      BAD_ORDER: id[victim] = id[victim] ^ (32'($urandom) | 32'h1);
      ORDER_THEN_EMPTY: begin
        id[0] = id[0] ^ (32'($urandom) | 32'h1);
        len[n - 1] = 64'd0;
      end
      HUGE_SECTION: len[n - 1] = {32'($urandom), 32'($urandom)} | 64'h0000_0100_0000_0000;
      default: ;
    endcase

    // Generate payloads and their hashes
    for (int s = 0; s < n; s++) begin
      h = HASH_SEED;
      gen = (flaw == HUGE_SECTION && s == n - 1) ? $urandom_range(0, 5) : int'(len[s]);
      for (int i = 0; i < gen; i++) begin
        b = $urandom;
        body.insert(body.size(), b);
        h = (h ^ 64'(b)) * HASH_PRIME;
      end
      sum[s] = h;
    end
    if (flaw == BAD_SUM || (flaw == EXTRA_BYTES && $urandom_range(0, 1) == 1))
      sum[victim] = sum[victim] ^ (64'd1 << $urandom_range(0, 63));

    for (int i = 0; i < 8; i++) img.insert(img.size(), MAGIC_TEXT[63 - 8 * i -: 8]);
    append_le(ver, 4);
    append_le(day, 8);
    append_le(cnt_field, 4);
    for (int s = 0; s < n; s++) begin
      append_le(id[s], 4);
      append_le(len[s], 8);
      append_le(sum[s], 8);
    end
    foreach (body[i]) img.insert(img.size(), body[i]);
    if (flaw == EXTRA_BYTES) repeat ($urandom_range(1, 4)) img.insert(img.size(), 8'($urandom));

    // Find the byte that raises the error, if any; keep up to three ignored bytes after it
    case (flaw)
      BAD_MAGIC: begin
        err_at = $urandom_range(0, 7);
        img[err_at] = img[err_at] ^ 8'($urandom_range(1, 255));
      end
      SHORT_MAGIC:      return $urandom_range(1, 7);
      BAD_VERSION:      err_at = 11;
      NEG_DAY:          err_at = 19;
      BAD_COUNT:        err_at = 23;
      EMPTY_SECTION:    err_at = 24 + 20 * victim + 19;
      ORDER_THEN_EMPTY: err_at = 24 + 20 * (n - 1) + 19;
      BAD_ORDER:        err_at = 24 + 20 * n - 1;
      CUT_SHORT:        return $urandom_range(8, img.size() - 1);
      default:          return img.size();
    endcase
    keep = err_at + 1 + $urandom_range(0, 3);
    return (keep > img.size()) ? img.size() : keep;
  endfunction

  function automatic flaw_t pick_flaw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CLEAN;
    if (r < 43) return BAD_SUM;
    if (r < 48) return BAD_MAGIC;
    if (r < 52) return SHORT_MAGIC;
    if (r < 57) return BAD_VERSION;
    if (r < 62) return NEG_DAY;
    if (r < 67) return BAD_COUNT;
    if (r < 72) return EMPTY_SECTION;
    if (r < 77) return BAD_ORDER;
    if (r < 80) return ORDER_THEN_EMPTY;
    if (r < 87) return CUT_SHORT;
    if (r < 91) return HUGE_SECTION;
    if (r < 96) return EXTRA_BYTES;
    return NOISE;
  endfunction

  // Offer one byte in bursts separated by random gaps; return once accepted
  task automatic send_byte(logic [7:0] b, logic fin);
    if (burst_left == 0) begin
      data_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= fin;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_image(int keep);
    for (int i = 0; i < keep; i++) send_byte(img[i], i == keep - 1);
  endtask

  // Hold the sender until every owed status item has arrived
  task automatic drain();
    data_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int    sent;
    int    reports;
    int    keep;
    flaw_t flaw;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // One container of each kind, then single-byte files at the byte extremes and of 0x57
    sent = 0;
    for (int f = 0; f <= NOISE; f++) begin
      keep = build(flaw_t'(f));
      send_image(keep);
      sent += keep;
    end
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h57, 1'b1);
    sent += 3;
    drain();

    // Short containers pile up behind the long receiver hold, then random ones
    reports = 0;
    while (sent < 750 || reports < 12) begin
      if (reports == 0) long_hold_go <= 1'b1;
      if (reports < 12) flaw = $urandom_range(0, 1) ? NOISE : SHORT_MAGIC;
      else flaw = pick_flaw();
      keep = build(flaw);
      send_image(keep);
      sent += keep;
      reports++;
      if ($urandom_range(0, 14) == 0) drain();
    end
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // End the run if nothing moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (data_valid && data_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/ccv_pkg.sv
sv/ccv_fnv.sv
sv/ccv_core.sv
sv/checkpoint_container_validator.sv
sv/ccv_checker.sv
verif/checkpoint_container_checker.sv
verif/checkpoint_container_validator_tb.sv
